[hdl/apsp_pkg.sv]
`default_nettype none

package apsp_pkg;

    // Field widths fixed by the channel definitions.
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 20;

    // Index widths sized for the largest supported graph (eight nodes).
    localparam int NODE_W   = 3;
    localparam int CELL_W   = 6;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Operation that the controller currently asks of the datapath.
    typedef enum logic [2:0] {
        DP_IDLE,
        DP_LOAD,
        DP_FETCH_A,
        DP_FETCH_CELL,
        DP_RELAX,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic                load_we;    // write the incoming weight
        logic                capture_a;  // latch leg(i,k) from the read port
        logic                off_diag;   // i differs from j
        logic [NODE_W-1:0]   k;
        logic [NODE_W-1:0]   i;
        logic [NODE_W-1:0]   j;
        logic [CELL_W-1:0]   addr;       // load or emit address
    } t_dp_cmd;

endpackage

`default_nettype wire

[hdl/apsp_if.sv]
`default_nettype none

interface apsp_weight_if;
    logic                              valid;
    logic                              ready;
    logic [apsp_pkg::WEIGHT_W-1:0]     weight;

    modport source (output valid, output weight, input ready);
    modport sink   (input valid, input weight, output ready);
endinterface

interface apsp_dist_if;
    logic                              valid;
    logic                              ready;
    logic [apsp_pkg::DIST_W-1:0]       distance;
    logic                              last_cell;

    modport source (output valid, output distance, output last_cell, input ready);
    modport sink   (input valid, input distance, input last_cell, output ready);
endinterface

`default_nettype wire

[hdl/apsp_ram.sv]
`default_nettype none

module apsp_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  wire logic [WIDTH-1:0]          i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]  i_rd_addr0,
    input  wire logic [$clog2(DEPTH)-1:0]  i_rd_addr1,
    output      logic [WIDTH-1:0]          o_rd_data0,
    output      logic [WIDTH-1:0]          o_rd_data1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data0 <= r_mem[i_rd_addr0];
        o_rd_data1 <= r_mem[i_rd_addr1];
    end

endmodule

`default_nettype wire

[hdl/apsp_datapath.sv]
`default_nettype none

module apsp_datapath #(
    parameter int NODES = 8
) (
    input  wire logic                              i_clk,
    input  wire apsp_pkg::t_dp_cmd                 i_cmd,
    input  wire logic [apsp_pkg::WEIGHT_W-1:0]     i_weight,
    output      logic [apsp_pkg::DIST_W-1:0]       o_distance
);

    localparam int CELLS  = NODES * NODES;
    localparam int ADDR_W = $clog2(CELLS);

    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [apsp_pkg::DIST_W-1:0]    wr_data;
    logic [ADDR_W-1:0]              rd_addr0;
    logic [ADDR_W-1:0]              rd_addr1;
    logic [apsp_pkg::DIST_W-1:0]    rd_data0;
    logic [apsp_pkg::DIST_W-1:0]    rd_data1;

    logic [apsp_pkg::DIST_W-1:0]    r_leg_a;
    logic [apsp_pkg::DIST_W:0]      sum_raw;
    logic [apsp_pkg::DIST_W-1:0]    sum_sat;
    logic                           take_sum;

    function automatic logic [ADDR_W-1:0] addr_of(
        input logic [apsp_pkg::NODE_W-1:0] row,
        input logic [apsp_pkg::NODE_W-1:0] col
    );
        logic [31:0] flat;
        flat = 32'(row) * 32'(NODES) + 32'(col);
        return flat[ADDR_W-1:0];
    endfunction

    // During relaxation port 0 returns leg(k,j) and port 1 the current cell (i,j).
    assign sum_raw  = {1'b0, r_leg_a} + {1'b0, rd_data0};
    assign sum_sat  = sum_raw[apsp_pkg::DIST_W] ? apsp_pkg::DIST_MAX
                                                : sum_raw[apsp_pkg::DIST_W-1:0];
    assign take_sum = i_cmd.off_diag && (r_leg_a != '0) && (rd_data0 != '0)
                      && ((sum_sat < rd_data1) || (rd_data1 == '0));

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = addr_of(i_cmd.i, i_cmd.j);
        wr_data  = sum_sat;
        rd_addr0 = i_cmd.addr[ADDR_W-1:0];
        rd_addr1 = addr_of(i_cmd.i, i_cmd.j);
        case (i_cmd.op)
            apsp_pkg::DP_LOAD: begin
                wr_en   = i_cmd.load_we;
                wr_addr = i_cmd.addr[ADDR_W-1:0];
                wr_data = apsp_pkg::DIST_W'(i_weight);
            end
            apsp_pkg::DP_FETCH_A: begin
                rd_addr0 = addr_of(i_cmd.i, i_cmd.k);
            end
            apsp_pkg::DP_FETCH_CELL: begin
                rd_addr0 = addr_of(i_cmd.k, i_cmd.j);
            end
            apsp_pkg::DP_RELAX: begin
                wr_en = take_sum;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_a) begin
            r_leg_a <= rd_data0;
        end
    end

    apsp_ram #(
        .WIDTH (apsp_pkg::DIST_W),
        .DEPTH (CELLS)
    ) u_cost_ram (
        .i_clk      (i_clk),
        .i_we       (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_addr0 (rd_addr0),
        .i_rd_addr1 (rd_addr1),
        .o_rd_data0 (rd_data0),
        .o_rd_data1 (rd_data1)
    );

    assign o_distance = rd_data0;

endmodule

`default_nettype wire

[hdl/apsp_ctrl.sv]
`default_nettype none

module apsp_ctrl #(
    parameter int NODES = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_out_ready,
    output      logic               o_in_ready,
    output      logic               o_out_valid,
    output      logic               o_last_cell,
    output      apsp_pkg::t_dp_cmd  o_cmd
);

    localparam int CELLS = NODES * NODES;
    localparam logic [apsp_pkg::CELL_W-1:0] LAST_CELL = apsp_pkg::CELL_W'(CELLS - 1);
    localparam logic [apsp_pkg::NODE_W-1:0] LAST_NODE = apsp_pkg::NODE_W'(NODES - 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH_A,
        S_FETCH_CELL,
        S_RELAX,
        S_EMIT_ISSUE,
        S_EMIT_SHOW
    } t_state;

    t_state                         r_state;
    logic [apsp_pkg::CELL_W-1:0]    r_count;
    logic [apsp_pkg::NODE_W-1:0]    r_k;
    logic [apsp_pkg::NODE_W-1:0]    r_i;
    logic [apsp_pkg::NODE_W-1:0]    r_j;
    logic                           r_a_pending;

    logic in_fire;
    logic out_fire;
    logic at_last;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_EMIT_SHOW);
    assign in_fire     = o_in_ready && i_in_valid;
    assign out_fire    = o_out_valid && i_out_ready;
    assign at_last     = (r_count == LAST_CELL);
    assign o_last_cell = at_last;

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = apsp_pkg::DP_IDLE;
        o_cmd.k         = r_k;
        o_cmd.i         = r_i;
        o_cmd.j         = r_j;
        o_cmd.addr      = r_count;
        o_cmd.off_diag  = (r_i != r_j);
        case (r_state)
            S_LOAD: begin
                o_cmd.op      = apsp_pkg::DP_LOAD;
                o_cmd.load_we = in_fire;
            end
            S_FETCH_A: begin
                o_cmd.op = apsp_pkg::DP_FETCH_A;
            end
            S_FETCH_CELL: begin
                o_cmd.op        = apsp_pkg::DP_FETCH_CELL;
                o_cmd.capture_a = r_a_pending;
            end
            S_RELAX: begin
                o_cmd.op = apsp_pkg::DP_RELAX;
            end
            S_EMIT_ISSUE: begin
                o_cmd.op = apsp_pkg::DP_EMIT;
            end
            S_EMIT_SHOW: begin
                o_cmd.op = apsp_pkg::DP_EMIT;
                // Prefetch the next cell as soon as the current one is taken.
                if (out_fire && !at_last) begin
                    o_cmd.addr = r_count + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_k         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_a_pending <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (at_last) begin
                            r_count <= '0;
                            r_k     <= '0;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= S_FETCH_A;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_FETCH_A: begin
                    r_a_pending <= 1'b1;
                    r_state     <= S_FETCH_CELL;
                end
                S_FETCH_CELL: begin
                    r_a_pending <= 1'b0;
                    r_state     <= S_RELAX;
                end
                S_RELAX: begin
                    if (r_j == LAST_NODE) begin
                        r_j <= '0;
                        if (r_i == LAST_NODE) begin
                            r_i <= '0;
                            if (r_k == LAST_NODE) begin
                                r_k     <= '0;
                                r_count <= '0;
                                r_state <= S_EMIT_ISSUE;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_state <= S_FETCH_A;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_FETCH_A;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_FETCH_CELL;
                    end
                end
                S_EMIT_ISSUE: begin
                    r_state <= S_EMIT_SHOW;
                end
                S_EMIT_SHOW: begin
                    if (out_fire) begin
                        if (at_last) begin
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/all_pairs_shortest_path.sv]
// All-pairs shortest path engine for a graph of NODES nodes.
// The weight channel takes one 16-bit edge weight per request, in row-major
// order of the NODES x NODES adjacency matrix; a weight of zero means no edge.
// Loading accepts one request per cycle while the source offers one.
// After the last weight, the block relaxes the matrix in place, cell by cell,
// over k, then i, then j. Each (k,i) row first reads leg(i,k); then, for each
// column, it reads both operands and then conditionally writes the cell. This
// loop through the single cost memory sets the block's rate.
// The distance channel then returns NODES*NODES requests in row-major order,
// with last_cell high on the final one. The first distance appears after
// relaxation ends and an issue state has read the first cell from the cost
// memory, and the later distances follow one per cycle while the
// receiver is ready. When the receiver stalls, the current distance holds
// steady on the port until it is taken. No new weight is accepted until the
// last distance has been delivered. A synchronous active-low reset returns
// the block to the loading phase with an empty matrix count; the cost memory
// itself is not cleared, since every cell is written before it is read.

`default_nettype none

module all_pairs_shortest_path #(
    parameter int NODES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    apsp_weight_if.sink      i_weight,
    apsp_dist_if.source      o_dist
);

    apsp_pkg::t_dp_cmd cmd;
    logic              in_ready;
    logic              out_valid;
    logic              last_cell;

    // The controller sequences the load, relaxation and emit phases.
    apsp_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_weight.valid),
        .i_out_ready (o_dist.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_last_cell (last_cell),
        .o_cmd       (cmd)
    );

    // The datapath owns the cost memory and the saturating add and compare.
    apsp_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_weight   (i_weight.weight),
        .o_distance (o_dist.distance)
    );

    assign i_weight.ready   = in_ready;
    assign o_dist.valid     = out_valid;
    assign o_dist.last_cell = last_cell;

endmodule

`default_nettype wire
